// ===== sv/button_hold_value_stepper_defines.svh =====
// Assertion macros for the button hold value stepper.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef BUTTON_HOLD_VALUE_STEPPER_DEFINES_SVH
`define BUTTON_HOLD_VALUE_STEPPER_DEFINES_SVH

// Consequence checked in the same cycle as the antecedent.
`define BHVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bhvs assertion failed");

// Consequence checked in the cycle after the antecedent.
`define BHVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bhvs assertion failed");

`endif

// ===== sv/bhvs_pkg.sv =====
// Shared types, codes and the per-button classifier of the button hold value stepper.
// No dependencies.
`default_nettype none

package bhvs_pkg;

    typedef logic [2:0] t_event;

    localparam t_event EV_NONE    = 3'd0;
    localparam t_event EV_PRESS   = 3'd1;
    localparam t_event EV_RELEASE = 3'd2;
    localparam t_event EV_HOLD    = 3'd3;
    localparam t_event EV_LONG    = 3'd4;

    typedef logic [1:0] t_mark;

    localparam t_mark MARK_UPPER   = 2'd0;
    localparam t_mark MARK_LOWER   = 2'd1;
    localparam t_mark MARK_BETWEEN = 2'd2;

    typedef logic [2:0] t_cfg_index;

    localparam t_cfg_index CFG_LOWER_LIMIT    = 3'd0;
    localparam t_cfg_index CFG_UPPER_LIMIT    = 3'd1;
    localparam t_cfg_index CFG_COARSE_STEP    = 3'd2;
    localparam t_cfg_index CFG_HOLD_THRESHOLD = 3'd3;
    localparam t_cfg_index CFG_LONG_THRESHOLD = 3'd4;

    localparam logic [15:0] LOWER_LIMIT_RESET    = 16'd100;
    localparam logic [15:0] UPPER_LIMIT_RESET    = 16'd260;
    localparam logic [9:0]  COARSE_STEP_RESET    = 10'd10;
    localparam logic [7:0]  HOLD_THRESHOLD_RESET = 8'd10;
    localparam logic [7:0]  LONG_THRESHOLD_RESET = 8'd48;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        t_event     ev;
        logic [7:0] cnt;
    } t_cls;

    // Sorts one button sample into an event and gives the next hold count.
    function automatic t_cls classify(input logic level, input logic prev,
                                      input logic [7:0] cnt, input logic [7:0] hold_th,
                                      input logic [7:0] long_th);
        t_cls res;
        res.ev  = EV_NONE;
        res.cnt = cnt;
        if (cnt < hold_th) begin
            if (level && !prev) begin
                res.ev = EV_PRESS;
            end else if (level && prev) begin
                if (cnt != COUNT_MAX) res.cnt = cnt + 8'd1;
            end else if (!level && prev) begin
                res.ev  = EV_RELEASE;
                res.cnt = 8'd0;
            end
        end else begin
            if (cnt > long_th) begin
                res.ev = EV_LONG;
            end else begin
                res.ev = EV_HOLD;
                if (cnt != COUNT_MAX) res.cnt = cnt + 8'd1;
            end
            // The tick that lets go still reports hold or long hold; only the count clears.
            if (!level && prev) res.cnt = 8'd0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/button_hold_value_stepper.sv =====
// A result is ready in the cycle after its input transaction is accepted.
// Throughput: one item per cycle while each result is taken; the output register frees as its result is taken.
// The step and clamp compares of minus, then plus, sit between input and result register.
// Reset (synchronous, active low) clears levels, hold counts and the setting, restores
// register defaults and empties the output register.
// Depends on bhvs_pkg and button_hold_value_stepper_defines.svh.
`default_nettype none

`include "button_hold_value_stepper_defines.svh"

module button_hold_value_stepper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_op,
    input  wire logic        i_minus_level,
    input  wire logic        i_plus_level,
    input  wire logic        i_ok_level,
    input  wire logic [15:0] i_load_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_setting_value,
    output logic [2:0]       o_minus_event,
    output logic [2:0]       o_plus_event,
    output logic [2:0]       o_ok_event,
    output logic             o_committed,
    output logic [1:0]       o_limit_mark
);

    logic [15:0] r_lower;
    logic [15:0] r_upper;
    logic [9:0]  r_coarse;
    logic [7:0]  r_hold_th;
    logic [7:0]  r_long_th;

    logic [2:0]  r_prev;
    logic [7:0]  r_cnt [3];
    logic [15:0] r_setting;

    logic              r_out_valid;
    bhvs_pkg::t_event  r_ev_m;
    bhvs_pkg::t_event  r_ev_p;
    bhvs_pkg::t_event  r_ev_o;
    logic              r_commit;
    bhvs_pkg::t_mark   r_mark;

    bhvs_pkg::t_cls    cls_m;
    bhvs_pkg::t_cls    cls_p;
    bhvs_pkg::t_cls    cls_o;
    logic [15:0]       v_m;
    logic [15:0]       v_p;
    logic [15:0]       n_setting;
    bhvs_pkg::t_event  n_ev_m;
    bhvs_pkg::t_event  n_ev_p;
    bhvs_pkg::t_event  n_ev_o;
    logic              n_commit;
    bhvs_pkg::t_mark   n_mark;
    logic              in_fire;
    logic              m_step;
    logic              p_step;
    logic [16:0]       coarse_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign coarse_ext = {7'd0, r_coarse};

    always_comb begin
        cls_m = bhvs_pkg::classify(i_minus_level, r_prev[0], r_cnt[0], r_hold_th, r_long_th);
        cls_p = bhvs_pkg::classify(i_plus_level, r_prev[1], r_cnt[1], r_hold_th, r_long_th);
        cls_o = bhvs_pkg::classify(i_ok_level, r_prev[2], r_cnt[2], r_hold_th, r_long_th);

        m_step = (cls_m.ev == bhvs_pkg::EV_PRESS || cls_m.ev == bhvs_pkg::EV_HOLD ||
                  cls_m.ev == bhvs_pkg::EV_LONG) && (r_setting > r_lower);
        v_m = r_setting;
        if (m_step) begin
            if (cls_m.ev != bhvs_pkg::EV_LONG) begin
                v_m = r_setting - 16'd1;
            end else if ({1'b0, r_setting} > ({1'b0, r_lower} + coarse_ext)) begin
                v_m = r_setting - {6'd0, r_coarse};
            end
        end

        p_step = (cls_p.ev == bhvs_pkg::EV_PRESS || cls_p.ev == bhvs_pkg::EV_HOLD ||
                  cls_p.ev == bhvs_pkg::EV_LONG) && (v_m < r_upper);
        v_p = v_m;
        if (p_step) begin
            if (cls_p.ev != bhvs_pkg::EV_LONG) begin
                v_p = v_m + 16'd1;
            end else if (({1'b0, v_m} + coarse_ext) < {1'b0, r_upper}) begin
                v_p = v_m + {6'd0, r_coarse};
            end
        end

        n_commit = 1'b0;
        if (i_op) begin
            n_setting = i_load_value;
            n_ev_m    = bhvs_pkg::EV_NONE;
            n_ev_p    = bhvs_pkg::EV_NONE;
            n_ev_o    = bhvs_pkg::EV_NONE;
        end else begin
            n_setting = v_p;
            n_ev_m    = cls_m.ev;
            n_ev_p    = cls_p.ev;
            n_ev_o    = cls_o.ev;
            // An ok press commits and takes precedence over the two-button reset.
            if (cls_o.ev == bhvs_pkg::EV_PRESS) begin
                n_commit = 1'b1;
            end else if (cls_m.ev == bhvs_pkg::EV_PRESS && cls_p.ev == bhvs_pkg::EV_PRESS) begin
                n_setting = r_lower;
            end
        end

        if (n_setting == r_upper) begin
            n_mark = bhvs_pkg::MARK_UPPER;
        end else if (n_setting == r_lower) begin
            n_mark = bhvs_pkg::MARK_LOWER;
        end else begin
            n_mark = bhvs_pkg::MARK_BETWEEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower   <= bhvs_pkg::LOWER_LIMIT_RESET;
            r_upper   <= bhvs_pkg::UPPER_LIMIT_RESET;
            r_coarse  <= bhvs_pkg::COARSE_STEP_RESET;
            r_hold_th <= bhvs_pkg::HOLD_THRESHOLD_RESET;
            r_long_th <= bhvs_pkg::LONG_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bhvs_pkg::CFG_LOWER_LIMIT:    r_lower   <= i_cfg_data;
                bhvs_pkg::CFG_UPPER_LIMIT:    r_upper   <= i_cfg_data;
                bhvs_pkg::CFG_COARSE_STEP:    r_coarse  <= i_cfg_data[9:0];
                bhvs_pkg::CFG_HOLD_THRESHOLD: r_hold_th <= i_cfg_data[7:0];
                bhvs_pkg::CFG_LONG_THRESHOLD: r_long_th <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= 3'd0;
            r_cnt[0]    <= 8'd0;
            r_cnt[1]    <= 8'd0;
            r_cnt[2]    <= 8'd0;
            r_setting   <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
                r_setting   <= n_setting;
                // A load transaction leaves the button state untouched.
                if (!i_op) begin
                    r_prev   <= {i_ok_level, i_plus_level, i_minus_level};
                    r_cnt[0] <= cls_m.cnt;
                    r_cnt[1] <= cls_p.cnt;
                    r_cnt[2] <= cls_o.cnt;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ev_m   <= n_ev_m;
            r_ev_p   <= n_ev_p;
            r_ev_o   <= n_ev_o;
            r_commit <= n_commit;
            r_mark   <= n_mark;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_setting_value = r_setting;
    assign o_minus_event   = r_ev_m;
    assign o_plus_event    = r_ev_p;
    assign o_ok_event      = r_ev_o;
    assign o_committed     = r_commit;
    assign o_limit_mark    = r_mark;

    `BHVS_ASSERT_NEXT(a_accept_gives_result, in_fire, o_out_valid)
    `BHVS_ASSERT_NEXT(a_load_sets_value, in_fire && i_op, o_setting_value == $past(i_load_value) && !o_committed)
    `BHVS_ASSERT_SAME(a_commit_is_ok_press, o_out_valid && o_committed, o_ok_event == bhvs_pkg::EV_PRESS)
    `BHVS_ASSERT_SAME(a_upper_mark_matches, o_out_valid && !i_cfg_we && o_limit_mark == bhvs_pkg::MARK_UPPER && $stable(r_upper), o_setting_value == r_upper)

endmodule

`default_nettype wire

// ===== bench/bhvs_tb_pkg.sv =====
// Codes shared by the stepper testbench top and its result checker.
// Depends on bhvs_pkg.
package bhvs_tb_pkg;

    import bhvs_pkg::*;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // No register lives at this index, so a write to it must change nothing.
    localparam t_cfg_index CFG_UNUSED_INDEX = 3'd7;

endpackage

// ===== bench/bhvs_result_checker.sv =====
// Result checker for the button hold value stepper: tracks register writes, predicts
// each result from the accepted input transactions and compares it field by field.
// Depends on bhvs_pkg and bhvs_tb_pkg.
module bhvs_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_op,
    input  logic        i_minus_level,
    input  logic        i_plus_level,
    input  logic        i_ok_level,
    input  logic [15:0] i_load_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_setting_value,
    input  logic [2:0]  i_minus_event,
    input  logic [2:0]  i_plus_event,
    input  logic [2:0]  i_ok_event,
    input  logic        i_committed,
    input  logic [1:0]  i_limit_mark,
    output int          o_fail_count,
    output int          o_pending
);

    import bhvs_pkg::*;
    import bhvs_tb_pkg::*;

    localparam int SLOT_DOWN = 0;
    localparam int SLOT_UP   = 1;
    localparam int SLOT_OK   = 2;

    typedef struct packed {
        logic [15:0] setting;
        t_event      minus_ev;
        t_event      plus_ev;
        t_event      ok_ev;
        logic        committed;
        t_mark       mark;
    } t_step_result;

    logic [15:0] lower_lim;
    logic [15:0] upper_lim;
    logic [9:0]  coarse;
    logic [7:0]  hold_th;
    logic [7:0]  long_th;

    logic [2:0]  level_hist;
    logic [7:0]  hold_cnt [3];
    logic [15:0] setting;

    t_step_result step_results_q [$];
    t_step_result oldest;
    int           fail_count = 0;
    int           waiting = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = waiting;

    // Sorts one button sample and advances that button's level history and hold count.
    function automatic t_event sort_button(input int idx, input logic level);
        logic       was_high;
        logic [7:0] held;
        t_event     ev;
        was_high = level_hist[idx];
        held     = hold_cnt[idx];
        ev       = EV_NONE;
        if (held < hold_th) begin
            if (level && !was_high) begin
                ev = EV_PRESS;
            end else if (level && was_high) begin
                if (held != 8'hFF) held = held + 8'd1;
            end else if (!level && was_high) begin
                ev   = EV_RELEASE;
                held = 8'd0;
            end
        end else begin
            if (held > long_th) begin
                ev = EV_LONG;
            end else begin
                ev = EV_HOLD;
                if (held != 8'hFF) held = held + 8'd1;
            end
            if (!level && was_high) held = 8'd0;
        end
        hold_cnt[idx]   = held;
        level_hist[idx] = level;
        return ev;
    endfunction

    function automatic logic moves(input t_event ev);
        return ev == EV_PRESS || ev == EV_HOLD || ev == EV_LONG;
    endfunction

    function automatic t_step_result advance_setting(input logic item_op, input logic m,
                                                     input logic p, input logic o,
                                                     input logic [15:0] value);
        t_step_result r;
        int unsigned  v;
        r = '0;
        v = setting;
        if (item_op == OP_LOAD) begin
            v = value;
        end else begin
            r.minus_ev = sort_button(SLOT_DOWN, m);
            r.plus_ev  = sort_button(SLOT_UP, p);
            r.ok_ev    = sort_button(SLOT_OK, o);
            if (moves(r.minus_ev) && v > lower_lim) begin
                if (r.minus_ev != EV_LONG) v = v - 1;
                else if (v > 32'(lower_lim) + 32'(coarse)) v = v - coarse;
            end
            if (moves(r.plus_ev) && v < upper_lim) begin
                if (r.plus_ev != EV_LONG) v = v + 1;
                else if (v + 32'(coarse) < 32'(upper_lim)) v = v + coarse;
            end
            // A commit on the same tick beats the two-button reset.
            if (r.ok_ev == EV_PRESS) r.committed = 1'b1;
            else if (r.minus_ev == EV_PRESS && r.plus_ev == EV_PRESS) v = lower_lim;
        end
        setting   = v[15:0];
        r.setting = setting;
        if (setting == upper_lim) r.mark = MARK_UPPER;
        else if (setting == lower_lim) r.mark = MARK_LOWER;
        else r.mark = MARK_BETWEEN;
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            if (fail_count < 10) begin
                $display("ERROR: %s expected %0d, got %0d at %0t", field, want, got, $realtime);
            end
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lower_lim  = LOWER_LIMIT_RESET;
            upper_lim  = UPPER_LIMIT_RESET;
            coarse     = COARSE_STEP_RESET;
            hold_th    = HOLD_THRESHOLD_RESET;
            long_th    = LONG_THRESHOLD_RESET;
            level_hist = '0;
            hold_cnt[SLOT_DOWN] = '0;
            hold_cnt[SLOT_UP]   = '0;
            hold_cnt[SLOT_OK]   = '0;
            setting    = '0;
            step_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOWER_LIMIT:    lower_lim = i_cfg_data;
                    CFG_UPPER_LIMIT:    upper_lim = i_cfg_data;
                    CFG_COARSE_STEP:    coarse    = i_cfg_data[9:0];
                    CFG_HOLD_THRESHOLD: hold_th   = i_cfg_data[7:0];
                    CFG_LONG_THRESHOLD: long_th   = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (step_results_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("ERROR: result transaction with nothing pending at %0t",
                                 $realtime);
                    end
                    fail_count++;
                end else begin
                    oldest = step_results_q.pop_front();
                    check_field("setting_value", oldest.setting, i_setting_value);
                    check_field("minus_event", oldest.minus_ev, i_minus_event);
                    check_field("plus_event", oldest.plus_ev, i_plus_event);
                    check_field("ok_event", oldest.ok_ev, i_ok_event);
                    check_field("committed", oldest.committed, i_committed);
                    check_field("limit_mark", oldest.mark, i_limit_mark);
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_results_q.push_back(advance_setting(i_op, i_minus_level, i_plus_level,
                                                         i_ok_level, i_load_value));
            end
        end
        waiting = step_results_q.size();
    end

endmodule

// ===== bench/tb_button_hold_value_stepper.sv =====
// Top of the button hold value stepper testbench: clock, reset, register writes,
// button gestures and loads under random stalls, and the final verdict.
// Depends on bhvs_pkg, bhvs_tb_pkg, bhvs_result_checker and the stepper RTL.
module tb_button_hold_value_stepper;

    import bhvs_pkg::*;
    import bhvs_tb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_index  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic        minus_level;
    logic        plus_level;
    logic        ok_level;
    logic [15:0] load_value;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] setting_value;
    logic [2:0]  minus_event;
    logic [2:0]  plus_event;
    logic [2:0]  ok_event;
    logic        committed;
    logic [1:0]  limit_mark;
    int          fail_count;
    int          pending;

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int items_sent = 0;

    // Copies of the register values, used only to shape the stimulus.
    int lower_now = 100;
    int upper_now = 260;
    int coarse_now = 10;
    int hold_now = 10;
    int long_now = 48;

    button_hold_value_stepper dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (op),
        .i_minus_level   (minus_level),
        .i_plus_level    (plus_level),
        .i_ok_level      (ok_level),
        .i_load_value    (load_value),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_setting_value (setting_value),
        .o_minus_event   (minus_event),
        .o_plus_event    (plus_event),
        .o_ok_event      (ok_event),
        .o_committed     (committed),
        .o_limit_mark    (limit_mark)
    );

    bhvs_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_op            (op),
        .i_minus_level   (minus_level),
        .i_plus_level    (plus_level),
        .i_ok_level      (ok_level),
        .i_load_value    (load_value),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_setting_value (setting_value),
        .i_minus_event   (minus_event),
        .i_plus_event    (plus_event),
        .i_ok_event      (ok_event),
        .i_committed     (committed),
        .i_limit_mark    (limit_mark),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // The receiver decides anew at every falling edge whether to take a result.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic send_item(input logic item_op, input logic m, input logic p,
                             input logic o, input logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op          = item_op;
        minus_level = m;
        plus_level  = p;
        ok_level    = o;
        load_value  = value;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic tick(input logic m, input logic p, input logic o);
        send_item(OP_TICK, m, p, o, 16'($urandom));
    endtask

    task automatic load_setting(input logic [15:0] value);
        send_item(OP_LOAD, 1'($urandom), 1'($urandom), 1'($urandom), value);
    endtask

    task automatic gesture(input logic m, input logic p, input logic o, input int dur);
        repeat (dur) tick(m, p, o);
        repeat ($urandom_range(2, 1)) tick(1'b0, 1'b0, 1'b0);
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Registers change only once every result of the previous setting is out.
    task automatic set_config(input int lo, input int up, input int step,
                              input int hold_ticks, input int long_ticks);
        wait_for_results();
        write_reg(CFG_LOWER_LIMIT, 16'(lo));
        write_reg(CFG_UPPER_LIMIT, 16'(up));
        write_reg(CFG_COARSE_STEP, 16'(step));
        write_reg(CFG_HOLD_THRESHOLD, 16'(hold_ticks));
        write_reg(CFG_LONG_THRESHOLD, 16'(long_ticks));
        lower_now  = lo;
        upper_now  = up;
        coarse_now = step;
        hold_now   = hold_ticks;
        long_now   = long_ticks;
    endtask

    // A value a coarse step or so around a limit, kept inside 16 bits.
    function automatic logic [15:0] near_value(input int limit);
        int x;
        x = limit + int'($urandom_range(2 * coarse_now + 8)) - (coarse_now + 4);
        if (x < 0) x = 0;
        if (x > 65535) x = 65535;
        return 16'(x);
    endfunction

    // Mostly clean gestures of random length, mixed with loads and noise ticks.
    task automatic run_random(input int count);
        int   goal;
        int   pick;
        int   dur;
        int   span;
        logic m;
        logic p;
        logic o;
        goal = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                wait_for_results();
            end else if (pick < 12) begin
                case ($urandom_range(2))
                    0: load_setting(near_value(lower_now));
                    1: load_setting(near_value(upper_now));
                    default: load_setting(16'($urandom));
                endcase
            end else if (pick < 24) begin
                tick(1'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                pick = $urandom_range(19);
                m = (pick <= 6) || (pick >= 16 && pick <= 18);
                p = (pick >= 7 && pick <= 13) || pick >= 16;
                o = pick == 14 || pick == 15 || pick >= 18;
                pick = $urandom_range(99);
                span = hold_now + long_now + 4;
                if (pick < 50) begin
                    dur = $urandom_range(4, 1);
                end else if (pick < 85) begin
                    dur = $urandom_range((span > 60) ? 60 : span, 1);
                end else begin
                    dur = hold_now + long_now + $urandom_range(20, 1);
                    if (dur > 300) dur = 300;
                end
                if (dur > goal - items_sent + 3) dur = goal - items_sent + 3;
                if (dur < 1) dur = 1;
                gesture(m, p, o, dur);
            end
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_LOWER_LIMIT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = OP_TICK;
        minus_level = 1'b0;
        plus_level  = 1'b0;
        ok_level    = 1'b0;
        load_value  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17;
        take_idle_pct = 84;

        // Directed part: short thresholds so hold and long hold come within a few ticks.
        set_config(100, 260, 10, 2, 3);
        load_setting(16'd0);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        load_setting(16'hFFFF);
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        load_setting(16'd150);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b0, 1'b0, 1'b0);
        gesture(1'b0, 1'b1, 1'b0, 7);
        load_setting(16'd260);
        gesture(1'b1, 1'b0, 1'b0, 6);

        set_config(100, 260, 10, 3, 8);
        run_random(100);

        wait_for_results();
        write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
        set_config(0, 65535, 1000, 1, 1);
        run_random(70);

        send_idle_pct = 84;
        take_idle_pct = 17;

        // Equal limits with large thresholds, 200 for hold and 254 for long hold.
        set_config(500, 500, 1, 200, 254);
        run_random(70);

        // Inverted limits, zero thresholds and a zero coarse step.
        set_config(1000, 900, 0, 0, 0);
        run_random(60);

        send_idle_pct = 0;
        take_idle_pct = 0;

        // With this long threshold a held button never reaches long hold, so its
        // count climbs to the top and must stay there.
        set_config(50, 60, 3, 2, 255);
        load_setting(16'd55);
        gesture(1'b0, 1'b1, 1'b0, 265);
        run_random(20);

        lower_now = $urandom_range(60000);
        upper_now = lower_now + $urandom_range(3000);
        if (upper_now > 65535) upper_now = 65535;
        set_config(lower_now, upper_now, $urandom_range(1000, 1), $urandom_range(5, 1),
                   $urandom_range(10, 1));
        run_random(40);

        wait_for_results();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bhvs_pkg.sv
sv/button_hold_value_stepper.sv
bench/bhvs_tb_pkg.sv
bench/bhvs_result_checker.sv
bench/tb_button_hold_value_stepper.sv
